### rtl/wthc_pkg.sv
// Package: shared types and constants for the word counter
`default_nettype none
package wthc_pkg;
   localparam int BYTE_W = 8;
   localparam int LEN_W = 5;
   localparam int CNT_W = 32;
   localparam int HASH_W = 32;
   localparam int SLOT_W = 12;
   // longest word whose bytes are kept and counted
   localparam int MAX_WORD = 22;
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C9DC5;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

   typedef enum logic [1:0] {
      ST_COUNTED  = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_input;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  word_count;
      logic [LEN_W-1:0]  word_length;
      logic [HASH_W-1:0] word_hash;
      logic              is_new;
      logic [1:0]        status;
   } rsp_type;

   function automatic logic is_sep(input logic [BYTE_W-1:0] b);
      return b == 8'd9 || b == 8'd10 || b == 8'd32;
   endfunction
endpackage
`default_nettype wire

### rtl/wthc_req_if.sv
// Interface: request channel carrying text bytes
`default_nettype none
interface wthc_req_if import wthc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/wthc_rsp_if.sv
// Interface: response channel carrying word results
`default_nettype none
interface wthc_rsp_if import wthc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/wthc_front.sv
// Front end: tokenizes bytes, hashes words, emits closed words into a queue
`default_nettype none
module wthc_front import wthc_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire req_type                    in_data,
   output logic                            wq_valid,
   input  wire logic                       wq_ready,
   output logic [MAX_WORD*BYTE_W-1:0]      wq_bytes,
   output logic [LEN_W-1:0]                wq_len,
   output logic [HASH_W-1:0]               wq_hash
);
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_WORD + 1);
   localparam int QD = 2;

   logic                          in_word_ff;
   logic [LEN_W-1:0]              len_ff;
   logic [HASH_W-1:0]             hash_ff;
   logic [MAX_WORD*BYTE_W-1:0]    bytes_ff;

   // two-entry queue of closed words
   logic [MAX_WORD*BYTE_W-1:0]    qb_ff [QD];
   logic [LEN_W-1:0]              ql_ff [QD];
   logic [HASH_W-1:0]             qh_ff [QD];
   logic                          qwp_ff, qrp_ff;
   logic [1:0]                    qn_ff;

   logic                          sep, take, push, pop, opened;
   logic [HASH_W-1:0]             hash_base, hash_new;
   logic [LEN_W-1:0]              len_base, len_new;
   logic [MAX_WORD*BYTE_W-1:0]    bytes_new;

   assign in_ready = (qn_ff < 2'(QD));
   assign take     = in_valid && in_ready;
   assign sep      = is_sep(in_data.text_byte);
   assign hash_base = in_word_ff ? hash_ff : FNV_BASIS;
   assign len_base  = in_word_ff ? len_ff : '0;
   assign hash_new  = (hash_base ^ {24'd0, in_data.text_byte}) * FNV_PRIME;
   assign len_new   = (len_base <= LEN_W'(MAX_WORD)) ? len_base + 1'b1 : len_base;
   always_comb begin
      bytes_new = bytes_ff;
      for (int i = 0; i < MAX_WORD; i++) begin
         if (len_base == LEN_W'(i)) bytes_new[i*BYTE_W +: BYTE_W] = in_data.text_byte;
      end
   end
   assign opened = in_word_ff || !sep;
   assign push   = take && ((sep && in_word_ff) || (in_data.end_of_input && opened));
   assign pop    = wq_valid && wq_ready;

   assign wq_valid = (qn_ff != 2'd0);
   assign wq_bytes = qb_ff[qrp_ff];
   assign wq_len   = ql_ff[qrp_ff];
   assign wq_hash  = qh_ff[qrp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         len_ff     <= '0;
         hash_ff    <= FNV_BASIS;
         qwp_ff     <= 1'b0;
         qrp_ff     <= 1'b0;
         qn_ff      <= '0;
      end else begin
         if (take) begin
            if (!sep) begin
               hash_ff  <= hash_new;
               len_ff   <= len_new;
               bytes_ff <= bytes_new;
            end
            in_word_ff <= !sep && !in_data.end_of_input;
         end
         if (push) begin
            qb_ff[qwp_ff] <= sep ? bytes_ff : bytes_new;
            ql_ff[qwp_ff] <= sep ? len_ff : len_new;
            qh_ff[qwp_ff] <= sep ? hash_ff : hash_new;
            qwp_ff        <= ~qwp_ff;
         end
         if (pop) qrp_ff <= ~qrp_ff;
         qn_ff <= qn_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) qn_ff <= 2'(QD))
      else $error("word queue overflow");
   assert property (@(posedge clock) disable iff (reset) push |-> in_ready)
      else $error("push without room");
   assert property (@(posedge clock) disable iff (reset)
      in_word_ff |-> (len_ff != '0 && len_ff <= LEN_CAP))
      else $error("open word length out of range");
endmodule
`default_nettype wire

### rtl/wthc_back.sv
// Back end: clears the table, probes it linearly, updates counts
`default_nettype none
module wthc_back import wthc_pkg::*; #(
   parameter int CAPACITY = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wq_valid,
   output logic                        wq_ready,
   input  wire logic [MAX_WORD*BYTE_W-1:0] wq_bytes,
   input  wire logic [LEN_W-1:0]       wq_len,
   input  wire logic [HASH_W-1:0]      wq_hash,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output rsp_type                     out_data
);
   localparam int IW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int PW = 2 * HASH_W;
   localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
   localparam logic [LEN_W-1:0] MAXW = LEN_W'(MAX_WORD);
   localparam logic [HASH_W-1:0] RECIP = HASH_W'(64'h1_0000_0000 / 64'(CAPACITY));

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_READ, S_CHECK, S_OUT} state_type;

   // key row holds length and bytes; count kept apart
   logic [MAX_WORD*BYTE_W+LEN_W-1:0] key_mem [CAPACITY];
   logic [CNT_W-1:0]                 cnt_mem [CAPACITY];
   logic [MAX_WORD*BYTE_W+LEN_W-1:0] key_rd_ff;
   logic [CNT_W-1:0]                 cnt_rd_ff;

   state_type          state_ff;
   logic [IW-1:0]      idx_ff;
   logic [OW-1:0]      steps_ff, occ_ff;
   logic [HASH_W-1:0]  q_ff;
   logic [HASH_W-1:0]  rem_ff;
   logic [1:0]         phase_ff;
   logic [MAX_WORD*BYTE_W-1:0] wb_ff;
   logic [LEN_W-1:0]   wl_ff;
   logic [HASH_W-1:0]  wh_ff;
   rsp_type            out_ff;
   logic               out_valid_ff;

   logic               match, empty;
   logic [MAX_WORD*BYTE_W-1:0] key_masked, wb_masked;
   logic [PW-1:0]      prod;
   logic [HASH_W-1:0]  qd;
   logic [HASH_W-1:0]  rem_fix;
   logic [HASH_W-1:0]  capw;
   logic [CNT_W-1:0]   cnt_inc;

   assign capw = HASH_W'(CAPACITY);
   // quotient estimate is low by at most one, so one subtract corrects it
   assign prod    = PW'(wh_ff) * PW'(RECIP);
   assign qd      = q_ff * capw;
   assign rem_fix = (rem_ff >= capw) ? rem_ff - capw : rem_ff;
   always_comb begin
      for (int i = 0; i < MAX_WORD; i++) begin
         key_masked[i*BYTE_W +: BYTE_W] = (LEN_W'(i) < wl_ff) ?
            key_rd_ff[i*BYTE_W +: BYTE_W] : '0;
         wb_masked[i*BYTE_W +: BYTE_W] = (LEN_W'(i) < wl_ff) ?
            wb_ff[i*BYTE_W +: BYTE_W] : '0;
      end
   end
   assign empty   = (cnt_rd_ff == '0);
   assign match   = key_rd_ff[MAX_WORD*BYTE_W +: LEN_W] == wl_ff && key_masked == wb_masked;
   assign cnt_inc = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + 1'b1;

   assign wq_ready  = (state_ff == S_IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) cnt_mem[idx_ff] <= '0;
      else if (state_ff == S_CHECK && (empty || match) && steps_ff != OW'(CAPACITY))
         cnt_mem[idx_ff] <= cnt_inc;
      if (state_ff == S_CHECK && empty && steps_ff != OW'(CAPACITY))
         key_mem[idx_ff] <= {wl_ff, wb_ff};
      key_rd_ff <= key_mem[idx_ff];
      cnt_rd_ff <= cnt_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               idx_ff <= (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
               if (idx_ff == LAST) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (wq_valid && wq_ready) begin
                  wb_ff <= wq_bytes;
                  wl_ff <= wq_len;
                  wh_ff <= wq_hash;
                  phase_ff <= '0;
                  steps_ff <= '0;
                  if (wq_len > MAXW) begin
                     out_ff <= '{slot: '0, word_count: '0,
                                 word_length: wq_len, word_hash: wq_hash,
                                 is_new: 1'b0, status: ST_TOO_LONG};
                     out_valid_ff <= 1'b1;
                  end else state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               // estimate quotient, form remainder, then correct it
               unique case (phase_ff)
                  2'd0: q_ff <= prod[PW-1:HASH_W];
                  2'd1: rem_ff <= wh_ff - qd;
                  default: begin
                     idx_ff <= rem_fix[IW-1:0];
                     state_ff <= S_READ;
                  end
               endcase
               phase_ff <= phase_ff + 1'b1;
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (steps_ff == OW'(CAPACITY)) begin
                  out_ff <= '{slot: '0, word_count: '0, word_length: wl_ff,
                              word_hash: wh_ff, is_new: 1'b0, status: ST_FULL};
                  state_ff <= S_OUT;
               end else if (empty || match) begin
                  out_ff <= '{slot: SLOT_W'(idx_ff), word_count: cnt_inc,
                              word_length: wl_ff, word_hash: wh_ff,
                              is_new: empty, status: ST_COUNTED};
                  if (empty) occ_ff <= occ_ff + 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_OUT: begin
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) occ_ff <= OW'(CAPACITY))
      else $error("occupancy beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && empty && steps_ff != OW'(CAPACITY)) |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("occupancy not advanced on new word");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> $stable(out_ff))
      else $error("result changed while stalled");
endmodule
`default_nettype wire

### rtl/word_tokenize_hash_count_top.sv
// Top level: streaming word counter with FNV-1a hashing and probed table
//   channel | dir | payload
//   req     | in  | text_byte, end_of_input
//   rsp     | out | slot, word_count, word_length, word_hash, is_new, status
// Bytes are taken one a cycle while the two-word queue has room.
// A closed word is taken when idle; its hash mod CAPACITY takes a quotient estimate,
// a remainder and a correction; each probe reads the single table port, then checks;
// the result is then raised. After reset a clearing pass empties the counts; bytes
// are still taken until the queue fills. Result stalls hold the back end only.
`default_nettype none
module word_tokenize_hash_count_top import wthc_pkg::*; #(
   parameter int CAPACITY = 4096
) (
   input wire logic   clock,
   input wire logic   reset,
   wthc_req_if.sink   req,
   wthc_rsp_if.source rsp
);
   logic                       wq_valid, wq_ready;
   logic [MAX_WORD*BYTE_W-1:0] wq_bytes;
   logic [LEN_W-1:0]           wq_len;
   logic [HASH_W-1:0]          wq_hash;

   wthc_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .wq_valid, .wq_ready, .wq_bytes, .wq_len, .wq_hash
   );

   wthc_back #(.CAPACITY(CAPACITY)) u_back (
      .clock, .reset,
      .wq_valid, .wq_ready, .wq_bytes, .wq_len, .wq_hash,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule
`default_nettype wire
